FILE: rtl/core/lrp_pkg.sv
// Shared types and codes for the LR parse engine.
// Holds item kinds, event and error codes, action codes and the sequencer states.
// No dependencies.
package lrp_pkg;

  localparam int unsigned KIND_W   = 3;
  localparam int unsigned SYM_W    = 7;
  localparam int unsigned STATE_W  = 8;
  localparam int unsigned TGT_W    = 8;
  localparam int unsigned PROD_W   = 8;
  localparam int unsigned LEN_W    = 4;
  localparam int unsigned CNT_W    = 6;
  localparam int unsigned REDUCE_LIMIT = 62;

  typedef enum logic [2:0] {
    KIND_TOKEN   = 3'd0,
    KIND_WR_ACT  = 3'd1,
    KIND_WR_GOTO = 3'd2,
    KIND_WR_PROD = 3'd3,
    KIND_RESTART = 3'd4
  } kind_t;

  typedef enum logic [2:0] {
    EV_ACK    = 3'd0,
    EV_REDUCE = 3'd1,
    EV_SHIFT  = 3'd2,
    EV_ACCEPT = 3'd3,
    EV_ERROR  = 3'd4,
    EV_IGNORE = 3'd5
  } event_t;

  typedef enum logic [2:0] {
    ERR_NONE     = 3'd0,
    ERR_NO_ACT   = 3'd1,
    ERR_NO_GOTO  = 3'd2,
    ERR_OVERFLOW = 3'd3,
    ERR_UNDER    = 3'd4,
    ERR_LIMIT    = 3'd5
  } err_t;

  typedef enum logic [1:0] {
    ACT_NONE   = 2'd0,
    ACT_SHIFT  = 2'd1,
    ACT_REDUCE = 2'd2,
    ACT_ACCEPT = 2'd3
  } act_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ACTD,
    ST_PROD,
    ST_BELOW,
    ST_GOTO
  } state_t;

endpackage

FILE: rtl/core/lrp_if.sv
// Channel interfaces for the LR parse engine: command items in, events out.
// Depends on nothing; widths match the fields of the package.
interface lrp_cmd_if;
  logic       valid;
  logic       ready;
  logic [2:0] kind;
  logic [6:0] symbol;
  logic [7:0] row_state;
  logic [1:0] action_code;
  logic [7:0] target;
  logic       entry_valid;
  logic [7:0] production_index;
  logic [3:0] rhs_length;

  modport source (output valid, kind, symbol, row_state, action_code, target,
                  entry_valid, production_index, rhs_length, input ready);
  modport sink (input valid, kind, symbol, row_state, action_code, target,
                entry_valid, production_index, rhs_length, output ready);
endinterface

interface lrp_evt_if;
  logic       valid;
  logic       ready;
  logic [2:0] event_res;
  logic [7:0] reduced_production;
  logic [6:0] event_symbol;
  logic [7:0] top_state;
  logic [2:0] error_code;
  logic       last;

  modport source (output valid, event_res, reduced_production, event_symbol,
                  top_state, error_code, last, input ready);
  modport sink (input valid, event_res, reduced_production, event_symbol,
                top_state, error_code, last, output ready);
endinterface

FILE: rtl/core/lr_table_driven_parse_engine.sv
// LR shift-reduce engine: tables, production list and state stack in synchronous RAMs.
// A write, restart or ignored item loads its event into the output register on acceptance;
// a token gives shift, accept or a lookup error after the action RAM read. Each reduce adds
// action, production, stack and goto RAM reads; underflow follows the production read and a
// missing goto the goto read. A full output register holds the sequencer. One item at a time.
// Reset: synchronous; a clearing pass then zeroes every entry of the action and goto tables.
module lr_table_driven_parse_engine
  import lrp_pkg::*;
#(
  parameter int NUM_STATES      = 256,
  parameter int NUM_SYMBOLS     = 128,
  parameter int NUM_PRODUCTIONS = 256,
  parameter int STACK_DEPTH     = 256,
  parameter int MAX_RHS         = 15
) (
  input logic     clk,
  input logic     rst,
  lrp_cmd_if.sink   cmd,
  lrp_evt_if.source evt
);

  // Table address is the row and the column side by side, each padded to a power of two.
  localparam int SW = $clog2(NUM_STATES);
  localparam int YW = $clog2(NUM_SYMBOLS);
  localparam int AW = SW + YW;
  localparam int TDEPTH = 1 << AW;
  localparam int QW = (NUM_PRODUCTIONS > 1) ? $clog2(NUM_PRODUCTIONS) : 1;
  localparam int PW = $clog2(STACK_DEPTH);

  // Memories. Stack entry 0 is never written: a read of it is taken as state zero.
  logic [9:0]         act_mem  [TDEPTH];
  logic [8:0]         goto_mem [TDEPTH];
  logic [10:0]        prod_mem [NUM_PRODUCTIONS];
  logic [7:0]         stk_mem  [STACK_DEPTH];

  logic [9:0]  act_q;
  logic [8:0]  goto_q;
  logic [10:0] prod_q;
  logic [7:0]  stk_q;

  // Control and working registers.
  state_t         state, state_next;
  logic [PW:0]    sp, sp_next;
  logic [7:0]     top, top_next;
  logic           done, done_next;
  logic [CNT_W-1:0] red_cnt, red_cnt_next;
  logic [6:0]     tok, tok_next;
  logic [7:0]     prod_r, prod_r_next;
  logic [6:0]     lhs_r, lhs_r_next;
  logic [3:0]     len_r, len_r_next;
  logic           below_zero, below_zero_next;
  logic           g_ok, g_ok_next;
  logic           clr_busy;
  logic [AW-1:0]  clr_cnt;

  // Output register.
  logic       ov;
  logic       out_free;
  logic       oload;
  logic [2:0] o_ev;
  logic [7:0] o_prod;
  logic [6:0] o_sym;
  logic [7:0] o_top;
  logic [2:0] o_err;
  logic       o_last;

  // Memory port controls.
  logic          act_we, act_re, goto_we, goto_re, prod_we, prod_re, stk_we, stk_re;
  logic [AW-1:0] act_raddr, goto_raddr, tab_waddr;
  logic [9:0]    act_wdata;
  logic [8:0]    goto_wdata;
  logic [QW-1:0] prod_waddr, prod_raddr;
  logic [10:0]   prod_wdata;
  logic [PW-1:0] stk_waddr, stk_raddr;
  logic [7:0]    stk_wdata;

  // Decoded conditions shared by the next-state and output blocks.
  logic        acc;
  logic        row_ok;
  logic [1:0]  act_code;
  logic [7:0]  act_tgt;
  logic        lookup_bad;
  logic        actd_reduce_go;
  logic        prod_under;
  logic [PW:0] below_idx;
  logic [7:0]  below;
  logic        goto_in_range;
  logic        goto_reduce_ok;
  logic [3:0]  rhs_clamped;
  logic [PW:0] sp_red;

  assign out_free  = !ov || evt.ready;
  assign cmd.ready = (state == ST_IDLE) && !clr_busy && out_free;
  assign acc       = cmd.valid && cmd.ready;

  always_comb begin
    row_ok      = (32'(cmd.row_state) < NUM_STATES) && (32'(cmd.symbol) < NUM_SYMBOLS);
    act_code    = act_q[9:8];
    act_tgt     = act_q[7:0];
    lookup_bad  = (32'(top) >= NUM_STATES) || (32'(tok) >= NUM_SYMBOLS);
    actd_reduce_go = !lookup_bad && (act_code == ACT_REDUCE) &&
                     (32'(red_cnt) < REDUCE_LIMIT) && (32'(act_tgt) < NUM_PRODUCTIONS);
    prod_under  = 32'(prod_q[3:0]) >= 32'(sp);
    below_idx   = sp - (PW + 1)'(prod_q[3:0]) - (PW + 1)'(1);
    below       = below_zero ? 8'd0 : stk_q;
    goto_in_range = (32'(below) < NUM_STATES) && (32'(lhs_r) < NUM_SYMBOLS);
    goto_reduce_ok = g_ok && goto_q[8] &&
                     !((len_r == 4'd0) && (32'(sp) >= STACK_DEPTH));
    rhs_clamped = (32'(cmd.rhs_length) > MAX_RHS) ? 4'(MAX_RHS) : cmd.rhs_length;
    sp_red      = sp - (PW + 1)'(len_r);
  end

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (acc && (cmd.kind == KIND_TOKEN) && !done) state_next = ST_ACTD;
      end
      ST_ACTD: begin
        if (actd_reduce_go) state_next = ST_PROD;
        else if (out_free) state_next = ST_IDLE;
      end
      ST_PROD: begin
        if (!prod_under) state_next = ST_BELOW;
        else if (out_free) state_next = ST_IDLE;
      end
      ST_BELOW: state_next = ST_GOTO;
      ST_GOTO: begin
        if (out_free) state_next = goto_reduce_ok ? ST_ACTD : ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Outputs of the sequencer: memory accesses, register updates and events.
  always_comb begin
    oload = 1'b0;
    o_ev = EV_ACK; o_prod = '0; o_sym = '0; o_top = top; o_err = ERR_NONE; o_last = 1'b1;
    act_we = 1'b0; act_re = 1'b0; goto_we = 1'b0; goto_re = 1'b0;
    prod_we = 1'b0; prod_re = 1'b0; stk_we = 1'b0; stk_re = 1'b0;
    tab_waddr  = {SW'(cmd.row_state), YW'(cmd.symbol)};
    act_wdata  = {cmd.action_code, cmd.target};
    goto_wdata = {cmd.entry_valid, cmd.target};
    act_raddr  = {SW'(top), YW'(cmd.symbol)};
    goto_raddr = {SW'(below), YW'(lhs_r)};
    prod_waddr = QW'(cmd.production_index);
    prod_wdata = {cmd.symbol, rhs_clamped};
    prod_raddr = QW'(act_tgt);
    stk_raddr  = below_idx[PW-1:0];
    stk_waddr  = sp[PW-1:0];
    stk_wdata  = act_tgt;
    sp_next = sp; top_next = top; done_next = done; red_cnt_next = red_cnt;
    tok_next = tok; prod_r_next = prod_r; lhs_r_next = lhs_r; len_r_next = len_r;
    below_zero_next = below_zero; g_ok_next = g_ok;

    if (clr_busy) begin
      act_we = 1'b1; goto_we = 1'b1;
      tab_waddr = clr_cnt; act_wdata = '0; goto_wdata = '0;
    end

    case (state)
      ST_IDLE: begin
        if (acc) begin
          oload = 1'b1;
          case (cmd.kind)
            KIND_TOKEN: begin
              if (done) begin
                o_ev = EV_IGNORE;
              end else begin
                oload = 1'b0;
                act_re = 1'b1;
                tok_next = cmd.symbol;
                red_cnt_next = '0;
              end
            end
            KIND_WR_ACT:  act_we  = row_ok;
            KIND_WR_GOTO: goto_we = row_ok;
            KIND_WR_PROD: prod_we = 32'(cmd.production_index) < NUM_PRODUCTIONS;
            KIND_RESTART: begin
              sp_next = (PW + 1)'(1); top_next = '0; done_next = 1'b0; o_top = '0;
            end
            default: o_ev = EV_IGNORE;
          endcase
        end
      end
      ST_ACTD: begin
        o_sym = tok;
        if (actd_reduce_go) begin
          prod_re = 1'b1;
          prod_r_next = act_tgt;
        end else if (out_free) begin
          oload = 1'b1;
          done_next = 1'b1;
          o_ev = EV_ERROR;
          o_err = ERR_NO_ACT;
          if (!lookup_bad) begin
            case (act_code)
              ACT_ACCEPT: begin
                o_ev = EV_ACCEPT; o_err = ERR_NONE;
              end
              ACT_SHIFT: begin
                if (32'(sp) >= STACK_DEPTH) begin
                  o_err = ERR_OVERFLOW;
                end else begin
                  done_next = 1'b0;
                  stk_we = 1'b1;
                  sp_next = sp + (PW + 1)'(1);
                  top_next = act_tgt;
                  o_ev = EV_SHIFT; o_err = ERR_NONE; o_top = act_tgt;
                end
              end
              ACT_REDUCE: begin
                if (32'(red_cnt) >= REDUCE_LIMIT) o_err = ERR_LIMIT;
              end
              default: o_err = ERR_NO_ACT;
            endcase
          end
        end
      end
      ST_PROD: begin
        o_sym = tok;
        if (!prod_under) begin
          stk_re = 1'b1;
          below_zero_next = (below_idx == '0);
          lhs_r_next = prod_q[10:4];
          len_r_next = prod_q[3:0];
        end else if (out_free) begin
          oload = 1'b1; done_next = 1'b1; o_ev = EV_ERROR; o_err = ERR_UNDER;
        end
      end
      ST_BELOW: begin
        goto_re = 1'b1;
        g_ok_next = goto_in_range;
      end
      ST_GOTO: begin
        o_sym = tok;
        if (out_free) begin
          oload = 1'b1;
          if (goto_reduce_ok) begin
            stk_we = 1'b1;
            stk_waddr = sp_red[PW-1:0];
            stk_wdata = goto_q[7:0];
            sp_next = sp_red + (PW + 1)'(1);
            top_next = goto_q[7:0];
            red_cnt_next = red_cnt + CNT_W'(1);
            act_re = 1'b1;
            act_raddr = {SW'(goto_q[7:0]), YW'(tok)};
            o_ev = EV_REDUCE; o_prod = prod_r; o_sym = lhs_r; o_top = goto_q[7:0];
            o_last = 1'b0;
          end else begin
            done_next = 1'b1;
            o_ev = EV_ERROR;
            o_err = (g_ok && goto_q[8]) ? ERR_OVERFLOW : ERR_NO_GOTO;
          end
        end
      end
      default: ;
    endcase
  end

  // Memories: one write and one registered read per cycle each.
  always_ff @(posedge clk) begin
    if (act_we) act_mem[tab_waddr] <= act_wdata;
    if (act_re) act_q <= act_mem[act_raddr];
  end

  always_ff @(posedge clk) begin
    if (goto_we) goto_mem[tab_waddr] <= goto_wdata;
    if (goto_re) goto_q <= goto_mem[goto_raddr];
  end

  always_ff @(posedge clk) begin
    if (prod_we) prod_mem[prod_waddr] <= prod_wdata;
    if (prod_re) prod_q <= prod_mem[prod_raddr];
  end

  always_ff @(posedge clk) begin
    if (stk_we) stk_mem[stk_waddr] <= stk_wdata;
    if (stk_re) stk_q <= stk_mem[stk_raddr];
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      sp <= (PW + 1)'(1);
      top <= '0;
      done <= 1'b0;
      red_cnt <= '0;
      clr_busy <= 1'b1;
      clr_cnt <= '0;
      ov <= 1'b0;
    end else begin
      state <= state_next;
      sp <= sp_next;
      top <= top_next;
      done <= done_next;
      red_cnt <= red_cnt_next;
      if (clr_busy) begin
        clr_cnt <= clr_cnt + AW'(1);
        if (clr_cnt == {AW{1'b1}}) clr_busy <= 1'b0;
      end
      if (oload) ov <= 1'b1;
      else if (evt.ready) ov <= 1'b0;
    end
  end

  // Working and payload registers need no reset.
  always_ff @(posedge clk) begin
    tok <= tok_next;
    prod_r <= prod_r_next;
    lhs_r <= lhs_r_next;
    len_r <= len_r_next;
    below_zero <= below_zero_next;
    g_ok <= g_ok_next;
    if (oload) begin
      evt.event_res <= o_ev;
      evt.reduced_production <= o_prod;
      evt.event_symbol <= o_sym;
      evt.top_state <= o_top;
      evt.error_code <= o_err;
      evt.last <= o_last;
    end
  end

  assign evt.valid = ov;

  // The stack always holds at least the bottom entry and never more than its depth.
  a_sp_range: assert property (@(posedge clk) disable iff (rst)
    (sp != '0) && (32'(sp) <= STACK_DEPTH))
    else $error("stack pointer out of range");

  // No item is taken while the tables are being cleared.
  a_no_accept_clear: assert property (@(posedge clk) disable iff (rst)
    clr_busy |-> !cmd.ready)
    else $error("item accepted during clearing pass");

  // A shift or reduce event reports the state that is then on top of the stack.
  a_top_follows: assert property (@(posedge clk) disable iff (rst)
    (oload && ((o_ev == EV_SHIFT) || (o_ev == EV_REDUCE))) |=> (top == evt.top_state))
    else $error("top state differs from event");

  // The reduction count for one token never passes the limit.
  a_red_limit: assert property (@(posedge clk) disable iff (rst)
    32'(red_cnt) <= REDUCE_LIMIT)
    else $error("reduction count past limit");

endmodule

FILE: tb/sv/tb_lrp_pkg.sv
`timescale 1ns / 100ps
// Test-side types for the LR parse engine testbench: one command record and one event record.
// Depends on lrp_pkg for the kind, event, error and action codes.
package tb_lrp_pkg;
  import lrp_pkg::*;

  typedef struct packed {
    logic [2:0] kind;
    logic [6:0] symbol;
    logic [7:0] row_state;
    logic [1:0] action_code;
    logic [7:0] target;
    logic       entry_valid;
    logic [7:0] production_index;
    logic [3:0] rhs_length;
  } cmd_rec_t;

  typedef struct packed {
    logic [2:0] event_res;
    logic [7:0] reduced_production;
    logic [6:0] event_symbol;
    logic [7:0] top_state;
    logic [2:0] error_code;
    logic       last;
  } evt_rec_t;
endpackage

FILE: tb/sv/tb_lrp_if.sv
`timescale 1ns / 100ps
// Interface instances used by the testbench are those of the design; this file holds the
// test-side clock generator. Depends on nothing.
interface tb_lrp_clkgen (output logic clk);
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end
endinterface

FILE: tb/sv/tb_lr_table_driven_parse_engine.sv
`timescale 1ns / 100ps
// Top-level testbench for the LR parse engine: loads small grammars, parses token streams
// and checks every event against a predictor of the engine. Depends on lrp_pkg, tb_lrp_pkg,
// the channel interfaces and the engine itself.
module tb_lr_table_driven_parse_engine;
  import lrp_pkg::*;
  import tb_lrp_pkg::*;

  logic clk;
  logic rst;
  int   fail_count;

  tb_lrp_clkgen u_clk (.clk(clk));
  lrp_cmd_if cmd ();
  lrp_evt_if evt ();

  lr_table_driven_parse_engine dut (.clk(clk), .rst(rst), .cmd(cmd), .evt(evt));

  // Predictor state: a private copy of the tables, production list and state stack.
  logic [9:0] act_mem [0:32767];
  logic [8:0] goto_mem [0:32767];
  logic [10:0] prod_mem [0:255];
  logic [7:0] stk [0:255];
  int unsigned depth;
  bit done_flag;
  bit prod_written [0:255];

  // Expected events, oldest first, and the stimulus waiting to be sent.
  evt_rec_t events_due[$];
  cmd_rec_t cmd_queue[$];
  // Rows of the directed table whose first event is typed in by hand.
  evt_rec_t hand_evt[$];
  bit       hand_has[$];

  bit idle_off;      // no idling in the last part of the run
  bit long_hold;     // receiver holds off while the sender keeps offering
  bit sending_done;

  // Append an expected event, or an item to send.
  task automatic due(input evt_rec_t e);
    events_due.insert(events_due.size(), e);
  endtask

  task automatic enqueue(input cmd_rec_t c);
    cmd_queue.insert(cmd_queue.size(), c);
  endtask

  function automatic evt_rec_t mk_evt(logic [2:0] ev, logic [7:0] prod, logic [6:0] sym,
                                      logic [7:0] top, logic [2:0] err, logic lst);
    evt_rec_t e;
    e.event_res = ev;
    e.reduced_production = prod;
    e.event_symbol = sym;
    e.top_state = top;
    e.error_code = err;
    e.last = lst;
    return e;
  endfunction

  function automatic logic [7:0] stack_top();
    if (depth == 0 || depth > 256) return 8'd0;
    return stk[depth-1];
  endfunction

  // Work out the events of one token and apply its effect on the stack.
  task automatic parse_token(input logic [6:0] tok);
    int unsigned nred;
    logic [7:0] top, tgt, below;
    logic [1:0] code;
    logic [6:0] lhs;
    logic [3:0] len;
    logic [8:0] g;
    nred = 0;
    forever begin
      top  = stack_top();
      code = act_mem[{top, tok}][9:8];
      tgt  = act_mem[{top, tok}][7:0];
      if (code == ACT_NONE) begin
        done_flag = 1;
        due(mk_evt(EV_ERROR, 0, tok, top, ERR_NO_ACT, 1));
        return;
      end
      if (code == ACT_ACCEPT) begin
        done_flag = 1;
        due(mk_evt(EV_ACCEPT, 0, tok, top, ERR_NONE, 1));
        return;
      end
      if (code == ACT_SHIFT) begin
        if (depth >= 256) begin
          done_flag = 1;
          due(mk_evt(EV_ERROR, 0, tok, top, ERR_OVERFLOW, 1));
          return;
        end
        stk[depth] = tgt;
        depth++;
        due(mk_evt(EV_SHIFT, 0, tok, tgt, ERR_NONE, 1));
        return;
      end
      if (nred >= REDUCE_LIMIT) begin
        done_flag = 1;
        due(mk_evt(EV_ERROR, 0, tok, top, ERR_LIMIT, 1));
        return;
      end
      lhs = prod_mem[tgt][10:4];
      len = prod_mem[tgt][3:0];
      if (len >= depth) begin
        done_flag = 1;
        due(mk_evt(EV_ERROR, 0, tok, top, ERR_UNDER, 1));
        return;
      end
      below = stk[depth-1-len];
      g = goto_mem[{below, lhs}];
      if (!g[8]) begin
        done_flag = 1;
        due(mk_evt(EV_ERROR, 0, tok, top, ERR_NO_GOTO, 1));
        return;
      end
      if (len == 0 && depth >= 256) begin
        done_flag = 1;
        due(mk_evt(EV_ERROR, 0, tok, top, ERR_OVERFLOW, 1));
        return;
      end
      depth = depth - len;
      stk[depth] = g[7:0];
      depth++;
      nred++;
      due(mk_evt(EV_REDUCE, tgt, lhs, g[7:0], ERR_NONE, 0));
    end
  endtask

  // Predict the events of one accepted command and update the private state.
  task automatic predict_item(input cmd_rec_t c);
    logic [3:0] len;
    case (c.kind)
      KIND_TOKEN: begin
        if (done_flag)
          due(mk_evt(EV_IGNORE, 0, 0, stack_top(), ERR_NONE, 1));
        else
          parse_token(c.symbol);
        return;
      end
      KIND_WR_ACT:  act_mem[{c.row_state, c.symbol}] = {c.action_code, c.target};
      KIND_WR_GOTO: goto_mem[{c.row_state, c.symbol}] = {c.entry_valid, c.target};
      KIND_WR_PROD: begin
        len = c.rhs_length; // MAX_RHS is 15, so every 4-bit length is stored as given
        prod_mem[c.production_index] = {c.symbol, len};
        prod_written[c.production_index] = 1;
      end
      KIND_RESTART: begin
        stk[0] = 0;
        depth = 1;
        done_flag = 0;
      end
      default: begin
        due(mk_evt(EV_IGNORE, 0, 0, stack_top(), ERR_NONE, 1));
        return;
      end
    endcase
    due(mk_evt(EV_ACK, 0, 0, stack_top(), ERR_NONE, 1));
  endtask

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
    fail_count++;
  endtask

  function automatic cmd_rec_t mk_cmd(logic [2:0] k, logic [6:0] sym, logic [7:0] row,
                                      logic [1:0] ac, logic [7:0] tgt, logic ev,
                                      logic [7:0] pi, logic [3:0] rl);
    cmd_rec_t c;
    c.kind = k;
    c.symbol = sym;
    c.row_state = row;
    c.action_code = ac;
    c.target = tgt;
    c.entry_valid = ev;
    c.production_index = pi;
    c.rhs_length = rl;
    return c;
  endfunction

  // Reductions are only allowed on productions that have been written. Reduce actions
  // in random grammars therefore point to production slots written up front.
  function automatic cmd_rec_t rand_noise();
    cmd_rec_t c;
    c = mk_cmd(3'($urandom_range(0, 7)), 7'($urandom), 8'($urandom), 2'($urandom),
               8'($urandom), 1'($urandom), 8'($urandom), 4'($urandom));
    if (c.kind == KIND_WR_ACT && c.action_code == ACT_REDUCE)
      c.target = 8'($urandom_range(0, 15));
    return c;
  endfunction

  // Builds a small random grammar over states 0..7 and symbols 0..7, then queues a
  // stream of tokens drawn evenly from symbols 0..7, with an occasional restart among them.
  task automatic queue_grammar_session();
    int ntok;
    logic [1:0] ac;
    logic [7:0] tg;
    enqueue(mk_cmd(KIND_RESTART, 0, 0, 0, 0, 0, 0, 0));
    for (int i = 0; i < 12; i++) begin
      ac = $urandom_range(0, 9) < 5 ? ACT_SHIFT :
           ($urandom_range(0, 3) == 0 ? ACT_ACCEPT : ACT_REDUCE);
      if ($urandom_range(0, 9) == 0) ac = ACT_NONE;
      tg = ac == ACT_REDUCE ? 8'($urandom_range(0, 15)) : 8'($urandom_range(0, 7));
      enqueue(mk_cmd(KIND_WR_ACT, 7'($urandom_range(0, 7)), 8'($urandom_range(0, 7)),
                     ac, tg, 0, 0, 0));
    end
    for (int i = 0; i < 6; i++)
      enqueue(mk_cmd(KIND_WR_GOTO, 7'($urandom_range(0, 7)), 8'($urandom_range(0, 7)),
                     0, 8'($urandom_range(0, 7)), $urandom_range(0, 5) != 0, 0, 0));
    ntok = $urandom_range(8, 20);
    for (int i = 0; i < ntok; i++)
      enqueue(mk_cmd($urandom_range(0, 19) == 0 ? KIND_RESTART : KIND_TOKEN,
                     7'($urandom_range(0, 7)), 0, 0, 0, 0, 0, 0));
  endtask

  // Directed table. A row with a hand-typed event is checked against it as well.
  task automatic add_row(input cmd_rec_t c, input bit has, input evt_rec_t e);
    enqueue(c);
    hand_has.insert(hand_has.size(), has);
    hand_evt.insert(hand_evt.size(), e);
  endtask

  task automatic build_directed();
    evt_rec_t z;
    z = '0;
    // Empty table after reset: the first token finds no action in state 0.
    add_row(mk_cmd(KIND_TOKEN, 7'd127, 0, 0, 0, 0, 0, 0), 1,
            mk_evt(EV_ERROR, 0, 127, 0, ERR_NO_ACT, 1));
    add_row(mk_cmd(KIND_TOKEN, 7'd3, 0, 0, 0, 0, 0, 0), 1,
            mk_evt(EV_IGNORE, 0, 0, 0, ERR_NONE, 1));
    add_row(mk_cmd(KIND_RESTART, 0, 0, 0, 0, 0, 0, 0), 1, mk_evt(EV_ACK, 0, 0, 0, 0, 1));
    add_row(mk_cmd(3'd7, 7'd5, 8'd255, 2'd3, 8'd255, 1, 8'd255, 4'd15), 1,
            mk_evt(EV_IGNORE, 0, 0, 0, ERR_NONE, 1));
    // Production extremes, then a tiny grammar S -> a S | (empty) style.
    add_row(mk_cmd(KIND_WR_PROD, 7'd127, 0, 0, 0, 0, 8'd255, 4'd15), 1,
            mk_evt(EV_ACK, 0, 0, 0, 0, 1));
    add_row(mk_cmd(KIND_WR_PROD, 7'd9, 0, 0, 0, 0, 8'd0, 4'd0), 0, z);
    add_row(mk_cmd(KIND_WR_PROD, 7'd9, 0, 0, 0, 0, 8'd1, 4'd2), 0, z);
    add_row(mk_cmd(KIND_WR_ACT, 7'd1, 8'd0, ACT_SHIFT, 8'd255, 0, 0, 0), 0, z);
    add_row(mk_cmd(KIND_WR_ACT, 7'd2, 8'd255, ACT_REDUCE, 8'd0, 0, 0, 0), 0, z);
    add_row(mk_cmd(KIND_WR_GOTO, 7'd9, 8'd255, 0, 8'd7, 1, 0, 0), 0, z);
    add_row(mk_cmd(KIND_WR_ACT, 7'd2, 8'd7, ACT_REDUCE, 8'd1, 0, 0, 0), 0, z);
    add_row(mk_cmd(KIND_WR_GOTO, 7'd9, 8'd0, 0, 8'd200, 1, 0, 0), 0, z);
    add_row(mk_cmd(KIND_WR_ACT, 7'd2, 8'd200, ACT_ACCEPT, 8'd0, 0, 0, 0), 0, z);
    add_row(mk_cmd(KIND_TOKEN, 7'd1, 0, 0, 0, 0, 0, 0), 1,
            mk_evt(EV_SHIFT, 0, 1, 255, ERR_NONE, 1));
    add_row(mk_cmd(KIND_TOKEN, 7'd2, 0, 0, 0, 0, 0, 0), 0, z);  // reduce, reduce, accept
    // Underflow: reduce by a long production on a short stack.
    add_row(mk_cmd(KIND_RESTART, 0, 0, 0, 0, 0, 0, 0), 0, z);
    add_row(mk_cmd(KIND_WR_ACT, 7'd4, 8'd0, ACT_REDUCE, 8'd255, 0, 0, 0), 0, z);
    add_row(mk_cmd(KIND_TOKEN, 7'd4, 0, 0, 0, 0, 0, 0), 1,
            mk_evt(EV_ERROR, 0, 4, 0, ERR_UNDER, 1));
    // Missing goto, and an empty production looping to hit the reduce limit.
    add_row(mk_cmd(KIND_RESTART, 0, 0, 0, 0, 0, 0, 0), 0, z);
    add_row(mk_cmd(KIND_WR_ACT, 7'd5, 8'd0, ACT_REDUCE, 8'd0, 0, 0, 0), 0, z);
    add_row(mk_cmd(KIND_WR_ACT, 7'd5, 8'd200, ACT_REDUCE, 8'd0, 0, 0, 0), 0, z);
    add_row(mk_cmd(KIND_WR_GOTO, 7'd9, 8'd200, 0, 8'd200, 1, 0, 0), 0, z);
    add_row(mk_cmd(KIND_TOKEN, 7'd5, 0, 0, 0, 0, 0, 0), 0, z);
    add_row(mk_cmd(KIND_WR_GOTO, 7'd9, 8'd200, 0, 8'd0, 0, 0, 0), 0, z);
    add_row(mk_cmd(KIND_RESTART, 0, 0, 0, 0, 0, 0, 0), 0, z);
    add_row(mk_cmd(KIND_TOKEN, 7'd5, 0, 0, 0, 0, 0, 0), 0, z);
  endtask

  // Overflow: a shift loop in state 255 pushes until the stack is full; the last token
  // overflows.
  task automatic queue_overflow();
    enqueue(mk_cmd(KIND_RESTART, 0, 0, 0, 0, 0, 0, 0));
    enqueue(mk_cmd(KIND_WR_ACT, 7'd1, 8'd255, ACT_SHIFT, 8'd255, 0, 0, 0));
    for (int i = 0; i < 256; i++)
      enqueue(mk_cmd(KIND_TOKEN, 7'd1, 0, 0, 0, 0, 0, 0));
    enqueue(mk_cmd(KIND_WR_ACT, 7'd1, 8'd255, ACT_NONE, 8'd0, 0, 0, 0));
  endtask

  // Sender: drives items with random bursts of idling until the queue is empty.
  initial begin : sender
    cmd_rec_t c;
    int gap;
    int base;
    cmd.valid <= 1'b0;
    {cmd.kind, cmd.symbol, cmd.row_state, cmd.action_code, cmd.target, cmd.entry_valid,
     cmd.production_index, cmd.rhs_length} <= '0;
    sending_done = 0;
    wait (rst === 1'b0);
    @(posedge clk);
    while (cmd_queue.size() != 0) begin
      c = cmd_queue.pop_front();
      {cmd.kind, cmd.symbol, cmd.row_state, cmd.action_code, cmd.target, cmd.entry_valid,
       cmd.production_index, cmd.rhs_length} <= c;
      cmd.valid <= 1'b1;
      do @(posedge clk); while (cmd.ready !== 1'b1);
      // The first event of this item lands after those still outstanding.
      base = events_due.size();
      predict_item(c);
      if (hand_has.size() != 0) begin
        if (hand_has.pop_front() && events_due.size() > base &&
            events_due[base] != hand_evt[0])
          report_mismatch("directed event", events_due[base], hand_evt[0]);
        void'(hand_evt.pop_front());
      end
      if (cmd_queue.size() == 0) begin
        cmd.valid <= 1'b0;
      end else if (!idle_off && $urandom_range(0, 5) == 0) begin
        cmd.valid <= 1'b0;
        gap = $urandom_range(1, 14);
        repeat (gap) @(posedge clk);
      end
    end
    sending_done = 1;
  end

  // Receiver: random stalls, one long hold-off, and checks every event.
  initial begin : receiver
    evt_rec_t got, want;
    int stall;
    evt.ready <= 1'b0;
    wait (rst === 1'b0);
    forever begin
      @(posedge clk);
      if (evt.valid === 1'b1 && evt.ready === 1'b1) begin
        got = {evt.event_res, evt.reduced_production, evt.event_symbol, evt.top_state,
               evt.error_code, evt.last};
        if (events_due.size() == 0) begin
          report_mismatch("event with none expected", got.event_res, 0);
        end else begin
          want = events_due.pop_front();
          if (got.event_res !== want.event_res)
            report_mismatch("event_res", got.event_res, want.event_res);
          if (got.reduced_production !== want.reduced_production)
            report_mismatch("reduced_production", got.reduced_production,
                            want.reduced_production);
          if (got.event_symbol !== want.event_symbol)
            report_mismatch("event_symbol", got.event_symbol, want.event_symbol);
          if (got.top_state !== want.top_state)
            report_mismatch("top_state", got.top_state, want.top_state);
          if (got.error_code !== want.error_code)
            report_mismatch("error_code", got.error_code, want.error_code);
          if (got.last !== want.last)
            report_mismatch("last", got.last, want.last);
        end
      end
      if (long_hold) begin
        evt.ready <= 1'b0;
        stall = 0;
        while (stall < 300) begin
          @(posedge clk);
          stall++;
        end
        long_hold = 0;
        evt.ready <= 1'b1;
      end else if (!idle_off && $urandom_range(0, 7) == 0) begin
        evt.ready <= 1'b0;
        repeat ($urandom_range(1, 14)) @(posedge clk);
        evt.ready <= 1'b1;
      end else begin
        evt.ready <= 1'b1;
      end
    end
  end

  // Main sequence: reset, clearing pass, directed part, random part, drain.
  initial begin : main_seq
    int settle;
    fail_count = 0;
    idle_off = 0;
    long_hold = 0;
    depth = 1;
    stk[0] = 0;
    done_flag = 0;
    for (int i = 0; i < 32768; i++) begin
      act_mem[i] = '0;
      goto_mem[i] = '0;
    end
    for (int i = 0; i < 256; i++) begin
      prod_mem[i] = '0;
      prod_written[i] = 0;
    end
    rst <= 1'b1;
    build_directed();
    // Production slots 0..15 are always written so random reduces stay in contract.
    for (int i = 0; i < 16; i++)
      enqueue(mk_cmd(KIND_WR_PROD, 7'($urandom_range(0, 7)), 0, 0, 0, 0, 8'(i),
                     4'($urandom_range(0, 3))));
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    queue_overflow();
    queue_grammar_session();
    for (int i = 0; i < 10; i++) enqueue(rand_noise());
    // The long hold-off happens while the sender keeps offering.
    wait (cmd_queue.size() < 60);
    long_hold = 1;
    queue_grammar_session();
    wait (cmd_queue.size() < 20);
    idle_off = 1;
    wait (sending_done);
    wait (events_due.size() == 0);
    settle = 0;
    while (settle < 300) begin
      @(posedge clk);
      settle++;
    end
    if (fail_count == 0 && events_due.size() == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

  initial begin : watchdog
    #20ms;
    $display("FAILURE");
    $finish;
  end
endmodule
